FILE: sv/imgrot90_pkg.sv
// ----------------------------------------------------------------------------
// imgrot90_pkg: shared definitions of the 90-degree frame rotator
// Register indexes, command codes, default sizes and the control and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package imgrot90_pkg;

	localparam int DEF_MAX_DIM    = 64;
	localparam int DEF_PIXEL_BITS = 24;

	localparam int CFG_W  = 7;
	localparam int IDX_W  = 2;
	localparam int CHAN_W = 8;
	localparam int RGB_W  = 3 * CHAN_W;

	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_TURN_RIGHT   = 2'd2;

	localparam logic [CFG_W-1:0] RST_FRAME_DIM = 7'd64;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic load;      // store the accepted pixel and step the load counter
		logic out_load;  // capture a result into the output register
		logic advance;   // step the read position after a valid rotated pixel
	} cmd_t;

	typedef struct packed {
		logic frame_full;
	} sts_t;

endpackage

FILE: sv/imgrot90_ram.sv
// ----------------------------------------------------------------------------
// imgrot90_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module imgrot90_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/imgrot90_ctrl.sv
// ----------------------------------------------------------------------------
// imgrot90_ctrl: transaction controller of the frame rotator
// Accepts load and read transactions, waits for the frame store read and
// for a free output register, and tracks the output valid flag.
// ----------------------------------------------------------------------------
module imgrot90_ctrl
	import imgrot90_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic command,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_fire;
	logic   slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd          = '0;
		cmd.load     = in_fire && (command == CMD_LOAD);
		cmd.out_load = (state_q == S_READ) && slot_free;
		cmd.advance  = cmd.out_load && sts.frame_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					// The store read is issued in the same cycle as the transaction.
					if (in_fire && (command == CMD_READ)) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: sv/imgrot90_dp.sv
// ----------------------------------------------------------------------------
// imgrot90_dp: datapath of the frame rotator
// Configuration registers, load and read position counters, rotated address
// generation, the frame store and the output register.
// ----------------------------------------------------------------------------
module imgrot90_dp
	import imgrot90_pkg::*;
#(
	parameter int MAX_DIM    = DEF_MAX_DIM,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic [CHAN_W-1:0] pixel_blue,
	input  logic [CHAN_W-1:0] pixel_green,
	input  logic [CHAN_W-1:0] pixel_red,
	input  cmd_t              cmd,
	output sts_t              sts,
	output logic [CHAN_W-1:0] out_blue,
	output logic [CHAN_W-1:0] out_green,
	output logic [CHAN_W-1:0] out_red,
	output logic              ready_res,
	output logic              frame_last
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int POS_W  = $clog2(MAX_DIM);

	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic             turn_right_q;

	logic [CNT_W-1:0] load_count_q;
	logic [POS_W-1:0] out_row_q;
	logic [POS_W-1:0] out_col_q;
	logic             frame_full_q;

	logic [CHAN_W-1:0] out_blue_q;
	logic [CHAN_W-1:0] out_green_q;
	logic [CHAN_W-1:0] out_red_q;
	logic              ready_res_q;
	logic              frame_last_q;

	logic [DIM_W-1:0]      w;
	logic [DIM_W-1:0]      h;
	logic [CNT_W-1:0]      total;
	logic                  restart;
	logic [CNT_W-1:0]      load_idx;
	logic [CNT_W-1:0]      load_next;
	logic [POS_W-1:0]      row_eff;
	logic [POS_W-1:0]      col_eff;
	logic [DIM_W-1:0]      row_plus;
	logic [DIM_W-1:0]      col_plus;
	logic [ADDR_W-1:0]     src_r;
	logic [ADDR_W-1:0]     src_c;
	logic [ADDR_W-1:0]     rd_addr;
	logic                  last;
	logic [RGB_W-1:0]      wr_rgb;
	logic [PIXEL_BITS-1:0] wr_word;
	logic [PIXEL_BITS-1:0] rd_word;
	logic [RGB_W-1:0]      rd_rgb;

	// Dimensions of zero act as one; values past the store size saturate.
	always_comb begin
		if (frame_width_q == '0) begin
			w = DIM_W'(1);
		end else if (32'(frame_width_q) > MAX_DIM) begin
			w = DIM_W'(MAX_DIM);
		end else begin
			w = DIM_W'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h = DIM_W'(1);
		end else if (32'(frame_height_q) > MAX_DIM) begin
			h = DIM_W'(MAX_DIM);
		end else begin
			h = DIM_W'(frame_height_q);
		end
	end

	assign total = CNT_W'(w) * CNT_W'(h);

	// A load after a finished frame, or past a frame that shrank, opens a new frame.
	assign restart   = frame_full_q || (load_count_q >= total);
	assign load_idx  = restart ? '0 : load_count_q;
	assign load_next = load_idx + CNT_W'(1);

	// The read position wraps when the dimensions changed after completion.
	assign row_eff  = (DIM_W'(out_row_q) >= w) ? '0 : out_row_q;
	assign col_eff  = (DIM_W'(out_col_q) >= h) ? '0 : out_col_q;
	assign row_plus = DIM_W'(row_eff) + DIM_W'(1);
	assign col_plus = DIM_W'(col_eff) + DIM_W'(1);

	always_comb begin
		if (turn_right_q) begin
			src_r = ADDR_W'(h) - ADDR_W'(1) - ADDR_W'(col_eff);
			src_c = ADDR_W'(row_eff);
		end else begin
			src_r = ADDR_W'(col_eff);
			src_c = ADDR_W'(w) - ADDR_W'(1) - ADDR_W'(row_eff);
		end
	end

	assign rd_addr = ADDR_W'(src_r * ADDR_W'(w)) + src_c;
	assign last    = (DIM_W'(row_eff) == w - DIM_W'(1)) && (DIM_W'(col_eff) == h - DIM_W'(1));

	assign wr_rgb  = {pixel_red, pixel_green, pixel_blue};
	assign wr_word = PIXEL_BITS'(wr_rgb);
	assign rd_rgb  = RGB_W'(rd_word);

	imgrot90_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.we      (cmd.load),
		.wr_addr (load_idx[ADDR_W-1:0]),
		.wr_data (wr_word),
		.rd_addr (rd_addr),
		.rd_data (rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_DIM;
			frame_height_q <= RST_FRAME_DIM;
			turn_right_q   <= 1'b0;
			load_count_q   <= '0;
			out_row_q      <= '0;
			out_col_q      <= '0;
			frame_full_q   <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
					REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
					REG_TURN_RIGHT:   turn_right_q   <= cfg_data[0];
					default: ;
				endcase
			end

			if (cmd.load) begin
				load_count_q <= load_next;
				frame_full_q <= (load_next >= total);
				if (restart) begin
					out_row_q <= '0;
					out_col_q <= '0;
				end
			end else if (cmd.advance) begin
				if (col_plus >= h) begin
					out_col_q <= '0;
					out_row_q <= (row_plus >= w) ? '0 : POS_W'(row_plus);
				end else begin
					out_col_q <= POS_W'(col_plus);
					out_row_q <= row_eff;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (frame_full_q) begin
				out_blue_q   <= rd_rgb[CHAN_W-1:0];
				out_green_q  <= rd_rgb[2*CHAN_W-1:CHAN_W];
				out_red_q    <= rd_rgb[3*CHAN_W-1:2*CHAN_W];
				ready_res_q  <= 1'b1;
				frame_last_q <= last;
			end else begin
				out_blue_q   <= '0;
				out_green_q  <= '0;
				out_red_q    <= '0;
				ready_res_q  <= 1'b0;
				frame_last_q <= 1'b0;
			end
		end
	end

	assign sts.frame_full = frame_full_q;
	assign out_blue       = out_blue_q;
	assign out_green      = out_green_q;
	assign out_red        = out_red_q;
	assign ready_res      = ready_res_q;
	assign frame_last     = frame_last_q;

endmodule

FILE: sv/image_rotate_90.sv
// A new load transaction is accepted every cycle while no read is pending.
// A read transaction goes through the registered frame store read and then
// the output register; out_valid rises once the output register is free and loaded.
// Reset clears the counters, frame_full, out_valid and turn_right at once and
// sets both frame sizes to 64; the frame store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// image_rotate_90: 90-degree frame rotator for RGB pixels
// Loads a frame in raster order and returns it rotated left or right,
// one pixel per read transaction, with the last pixel marked.
// ----------------------------------------------------------------------------
module image_rotate_90
	import imgrot90_pkg::*;
#(
	parameter int MAX_DIM    = DEF_MAX_DIM,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              command,
	input  logic [CHAN_W-1:0] pixel_blue,
	input  logic [CHAN_W-1:0] pixel_green,
	input  logic [CHAN_W-1:0] pixel_red,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAN_W-1:0] out_blue,
	output logic [CHAN_W-1:0] out_green,
	output logic [CHAN_W-1:0] out_red,
	output logic              ready_res,
	output logic              frame_last
);

	cmd_t cmd;
	sts_t sts;

	imgrot90_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	imgrot90_dp #(
		.MAX_DIM    (MAX_DIM),
		.PIXEL_BITS (PIXEL_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_blue  (pixel_blue),
		.pixel_green (pixel_green),
		.pixel_red   (pixel_red),
		.cmd         (cmd),
		.sts         (sts),
		.out_blue    (out_blue),
		.out_green   (out_green),
		.out_red     (out_red),
		.ready_res   (ready_res),
		.frame_last  (frame_last)
	);

`ifndef NO_ASSERTIONS
	// A read transaction holds off the next transaction for its store read.
	a_read_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (command == CMD_READ)) |=> !in_ready)
		else $error("input accepted during a pending read");

	// The read position only moves on a result taken from a complete frame.
	a_advance_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> (sts.frame_full && cmd.out_load && !cmd.load))
		else $error("read position stepped without a complete frame");

	// The end-of-frame mark only comes with a valid rotated pixel.
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_last) |-> ready_res)
		else $error("frame_last set on a result without ready_res");

	// A read accepted while the output register is free has its result captured in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (command == CMD_READ) && (!out_valid || out_ready))
		|=> cmd.out_load)
		else $error("result not captured after the store read");
`endif

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 90-degree frame rotator
// Loads frames of many sizes, reads them back rotated left and right, and
// checks every rotated pixel against a behavioral copy of the rotator. Both
// handshake sides idle at random, and one long output stall backs up the block.
// ----------------------------------------------------------------------------
module testbench;
	import imgrot90_pkg::*;

	localparam int DIM          = DEF_MAX_DIM;
	localparam int IDLE_PCT     = 22;
	localparam int ITEM_TARGET  = 1600;
	localparam int SETTLE       = 4;
	localparam int HOLD_CYCLES  = 150;
	localparam int STALL_LIMIT  = 1000;

	typedef struct {
		logic              cmd;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} pixel_cmd_t;

	typedef struct {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
		logic              valid_px;
		logic              last;
	} rotated_px_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_write = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              command = CMD_LOAD;
	logic [CHAN_W-1:0] pixel_blue = '0;
	logic [CHAN_W-1:0] pixel_green = '0;
	logic [CHAN_W-1:0] pixel_red = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [CHAN_W-1:0] out_blue;
	logic [CHAN_W-1:0] out_green;
	logic [CHAN_W-1:0] out_red;
	logic              ready_res;
	logic              frame_last;

	pixel_cmd_t  pending_cmds[$];
	rotated_px_t expected_pixels[$];

	bit in_taken = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int idle_pct = IDLE_PCT;
	int results_seen = 0;
	int mismatches = 0;
	int items_queued = 0;
	int stall_cycles = 0;

	// Behavioral copy of the rotator state and its configuration.
	logic [RGB_W-1:0] frame_mem [DIM*DIM];
	int unsigned      load_cnt = 0;
	int unsigned      rd_row = 0;
	int unsigned      rd_col = 0;
	bit               full_flag = 1'b0;
	logic [CFG_W-1:0] cfg_w = RST_FRAME_DIM;
	logic [CFG_W-1:0] cfg_h = RST_FRAME_DIM;
	bit               cfg_right = 1'b0;

	image_rotate_90 uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.pixel_blue(pixel_blue),
		.pixel_green(pixel_green),
		.pixel_red(pixel_red),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_blue(out_blue),
		.out_green(out_green),
		.out_red(out_red),
		.ready_res(ready_res),
		.frame_last(frame_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > DIM)
			return DIM;
		return 32'(v);
	endfunction

	// Applies one accepted command to the behavioral rotator.
	function automatic void rotate_step(input pixel_cmd_t c, output bit produced,
			output rotated_px_t px);
		int unsigned w, h, total, src_r, src_c;
		logic [RGB_W-1:0] word;
		w = eff_dim(cfg_w);
		h = eff_dim(cfg_h);
		total = w * h;
		produced = 1'b0;
		px.blue = '0;
		px.green = '0;
		px.red = '0;
		px.valid_px = 1'b0;
		px.last = 1'b0;
		if (c.cmd == CMD_LOAD) begin
			// A load after a finished frame, or past a shrunken frame, restarts.
			if (full_flag || load_cnt >= total) begin
				load_cnt = 0;
				rd_row = 0;
				rd_col = 0;
				full_flag = 1'b0;
			end
			frame_mem[load_cnt % (DIM*DIM)] = {c.red, c.green, c.blue};
			load_cnt++;
			if (load_cnt >= total)
				full_flag = 1'b1;
		end else begin
			produced = 1'b1;
			if (full_flag) begin
				if (rd_row >= w)
					rd_row = 0;
				if (rd_col >= h)
					rd_col = 0;
				if (cfg_right) begin
					src_r = h - 1 - rd_col;
					src_c = rd_row;
				end else begin
					src_r = rd_col;
					src_c = w - 1 - rd_row;
				end
				word = frame_mem[(src_r * w + src_c) % (DIM*DIM)];
				px.blue = word[CHAN_W-1:0];
				px.green = word[2*CHAN_W-1:CHAN_W];
				px.red = word[RGB_W-1:2*CHAN_W];
				px.valid_px = 1'b1;
				px.last = (rd_row == w - 1) && (rd_col == h - 1);
				rd_col++;
				if (rd_col >= h) begin
					rd_col = 0;
					rd_row++;
					if (rd_row >= w)
						rd_row = 0;
				end
			end
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [CHAN_W-1:0] seen,
			input logic [CHAN_W-1:0] want);
		if (seen !== want)
			report_mismatch($sformatf("result %0d %s got %h expected %h",
				results_seen, name, seen, want));
	endtask

	// Sampling side: accepted commands feed the predictor, results are checked.
	always @(posedge clk) begin : sample
		pixel_cmd_t  taken;
		rotated_px_t want;
		bit          produced;
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			taken.cmd = command;
			taken.blue = pixel_blue;
			taken.green = pixel_green;
			taken.red = pixel_red;
			rotate_step(taken, produced, want);
			if (produced)
				expected_pixels.push_back(want);
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no read pending",
					results_seen));
			end else begin
				want = expected_pixels.pop_front();
				check_field("out_blue", out_blue, want.blue);
				check_field("out_green", out_green, want.green);
				check_field("out_red", out_red, want.red);
				check_field("ready_res", CHAN_W'(ready_res), CHAN_W'(want.valid_px));
				check_field("frame_last", CHAN_W'(frame_last), CHAN_W'(want.last));
			end
			results_seen++;
		end
	end

	// Command driver: holds each transaction until it is taken.
	always @(negedge clk) begin : feed
		pixel_cmd_t nxt;
		if (!in_valid || in_taken) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
				nxt = pending_cmds.pop_front();
				in_valid <= 1'b1;
				command <= nxt.cmd;
				pixel_blue <= nxt.blue;
				pixel_green <= nxt.green;
				pixel_red <= nxt.red;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver. Once, while reads are backed up, it stops taking results
	// for a long stretch so the block fills and pushes back on its input.
	always @(negedge clk) begin
		if (!hold_done && results_seen >= 150 && pending_cmds.size() > 16
				&& expected_pixels.size() >= 2) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("[image_rotate_90] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic queue_load(input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
			input logic [CHAN_W-1:0] r);
		pixel_cmd_t c;
		c.cmd = CMD_LOAD;
		c.blue = b;
		c.green = g;
		c.red = r;
		pending_cmds.push_back(c);
		items_queued++;
	endtask

	task automatic queue_rand_load();
		queue_load(CHAN_W'($urandom_range(255)), CHAN_W'($urandom_range(255)),
			CHAN_W'($urandom_range(255)));
	endtask

	task automatic queue_read();
		pixel_cmd_t c;
		c.cmd = CMD_READ;
		c.blue = CHAN_W'($urandom_range(255));
		c.green = CHAN_W'($urandom_range(255));
		c.red = CHAN_W'($urandom_range(255));
		pending_cmds.push_back(c);
		items_queued++;
	endtask

	// Waits until every command is taken and every result has been checked.
	task automatic wait_idle();
		while (pending_cmds.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_FRAME_WIDTH: cfg_w = value;
			REG_FRAME_HEIGHT: cfg_h = value;
			REG_TURN_RIGHT: cfg_right = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] pick_dim();
		case ($urandom_range(9))
			0: return CFG_W'(0);
			1: return CFG_W'(1);
			2: return CFG_W'(DIM);
			3: return CFG_W'($urandom_range(DIM + 1, 127));
			default: return CFG_W'($urandom_range(2, 8));
		endcase
	endfunction

	// One well-formed frame: finish the fill, read it back one or two times,
	// with an occasional stray transaction. Every phase opens with a load, so a
	// read never reaches a store entry that was not written for this frame.
	task automatic queue_frame(input bit tail_partial);
		int unsigned total, fill, reads;
		total = eff_dim(cfg_w) * eff_dim(cfg_h);
		fill = (!full_flag && load_cnt < total) ? total - load_cnt : total;
		for (int i = 0; i < fill; i++) begin
			if (i != 0 && $urandom_range(99) < 5)
				queue_read();
			queue_rand_load();
		end
		reads = $urandom_range(1, 2) * total + $urandom_range(0, 3);
		for (int i = 0; i < reads; i++) begin
			if ($urandom_range(99) < 2)
				queue_rand_load();
			queue_read();
		end
		if (tail_partial)
			repeat ($urandom_range(1, total)) queue_rand_load();
	endtask

	initial begin : stimulus
		logic [CFG_W-1:0] raw_w, raw_h;
		logic             right;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reads before any frame is complete, and the extreme pixel values.
		queue_read();
		queue_load(8'h00, 8'h00, 8'h00);
		queue_load(8'hFF, 8'hFF, 8'hFF);
		queue_read();
		wait_idle();

		// Shrink mid-frame to 2x3, finish it, read one pixel past the end.
		write_reg(REG_FRAME_WIDTH, 7'd2);
		write_reg(REG_FRAME_HEIGHT, 7'd3);
		queue_load(8'h01, 8'h80, 8'hFE);
		queue_load(8'h7F, 8'h55, 8'hAA);
		queue_load(8'hAA, 8'h01, 8'h80);
		queue_load(8'h55, 8'hFE, 8'h7F);
		repeat (7) queue_read();
		wait_idle();

		write_reg(REG_TURN_RIGHT, 7'd1);
		repeat (6) queue_read();
		wait_idle();

		// Zero sizes act as one: a load on a full frame starts a 1x1 frame.
		write_reg(REG_FRAME_WIDTH, 7'd0);
		write_reg(REG_FRAME_HEIGHT, 7'd0);
		queue_load(8'hC3, 8'h3C, 8'h96);
		queue_read();
		queue_read();
		wait_idle();

		for (int phase = 0; items_queued < ITEM_TARGET; phase++) begin
			idle_pct = (phase >= 6 && phase < 9) ? 0 : IDLE_PCT;
			case (phase)
				0: begin
					raw_w = 7'd127;
					raw_h = 7'd1;
					right = 1'b0;
				end
				1: begin
					raw_w = 7'd2;
					raw_h = 7'd2;
					right = 1'b1;
				end
				2: begin
					raw_w = 7'd1;
					raw_h = CFG_W'(DIM);
					right = 1'b1;
				end
				default: begin
					raw_w = pick_dim();
					raw_h = pick_dim();
					right = 1'($urandom_range(1));
					if (eff_dim(raw_w) * eff_dim(raw_h) > 128)
						raw_h = CFG_W'($urandom_range(1, 2));
				end
			endcase
			write_reg(REG_FRAME_WIDTH, raw_w);
			write_reg(REG_FRAME_HEIGHT, raw_h);
			write_reg(REG_TURN_RIGHT, CFG_W'(right));
			queue_frame(phase == 0 || $urandom_range(3) == 0);
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[image_rotate_90] OK");
		else
			$display("[image_rotate_90] ERROR");
		$finish;
	end

endmodule
